>>> design/wls_pkg.sv
// ----------------------------------------------------------------------------
// wls_pkg: shared types and constants of the window/level stretch
// Field widths, item classes, register indexes and reset values.
// ----------------------------------------------------------------------------
package wls_pkg;

  // fixed field widths
  localparam int OUT_W     = 16;  // mapped_value, out_max
  localparam int WW_W      = 16;  // window_width
  localparam int QUO_W     = 16;  // quotient bits, one divider stage each
  localparam int PROD_W    = 32;  // out_max * offset
  localparam int CFG_IDX_W = 2;

  // register indexes on the config channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_WIDTH = 2'd0,
    REG_WINDOW_LEVEL = 2'd1,
    REG_OUT_MAX      = 2'd2
  } cfg_reg_e;

  // reset values
  localparam logic [WW_W-1:0]  RST_WINDOW_WIDTH = 16'd256;
  localparam int               RST_WINDOW_LEVEL = 128;
  localparam logic [OUT_W-1:0] RST_OUT_MAX      = 16'd255;

  // how an item resolves: clamp low, clamp high or go through the divider
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FULL = 2'd1,
    CLS_DIV  = 2'd2
  } cls_e;

  // fixed-width part of the active configuration
  typedef struct packed {
    logic             thr_mode;  // window of zero: plain threshold
    logic [OUT_W-1:0] out_max;
    logic [WW_W-1:0]  span;      // high - low = 2 * half
  } cfg_t;

endpackage

>>> design/wls_if.sv
// ----------------------------------------------------------------------------
// wls_if: channel interfaces of the window/level stretch
// Voxel input, mapped output and register write channels.
// ----------------------------------------------------------------------------
interface wls_voxel_if #(
  parameter int IB = 17
);
  logic          valid;
  logic          ready;
  logic [IB-1:0] voxel_value;

  modport source (output valid, output voxel_value, input ready);
  modport sink   (input valid, input voxel_value, output ready);
endinterface

interface wls_map_if import wls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] mapped_value;

  modport source (output valid, output mapped_value, input ready);
  modport sink   (input valid, input mapped_value, output ready);
endinterface

interface wls_cfg_if import wls_pkg::*; #(
  parameter int DW = 17
);
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DW-1:0]        wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> design/wls_cfg_regs.sv
// ----------------------------------------------------------------------------
// wls_cfg_regs: configuration registers
// Holds window width, level and out_max, and registers the band edges.
// ----------------------------------------------------------------------------
module wls_cfg_regs import wls_pkg::*; #(
  parameter int IB = 17,
  parameter int BW = 19,
  parameter int DW = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  logic [CFG_IDX_W-1:0] wr_index_i,
  input  logic [DW-1:0]        wr_data_i,
  output cfg_t                 cfg_o,
  output logic signed [BW-1:0] low_o,
  output logic signed [BW-1:0] high_o,
  output logic                 busy_o
);

  logic [WW_W-1:0]       ww_q;
  logic signed [IB-1:0]  level_q;
  logic [OUT_W-1:0]      omax_q;
  logic signed [BW-1:0]  low_q, high_q;
  cfg_t                  cfg_q;
  logic                  busy_q;
  logic signed [BW-1:0]  lvl_ext;
  logic signed [BW-1:0]  half_ext;

  assign wr_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ww_q    <= RST_WINDOW_WIDTH;
      level_q <= IB'(RST_WINDOW_LEVEL);
      omax_q  <= RST_OUT_MAX;
    end else if (wr_valid_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        REG_WINDOW_WIDTH: ww_q    <= wr_data_i[WW_W-1:0];
        REG_WINDOW_LEVEL: level_q <= wr_data_i[IB-1:0];
        REG_OUT_MAX:      omax_q  <= wr_data_i[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // band edges, registered from the width and level registers
  assign lvl_ext  = {{(BW-IB){level_q[IB-1]}}, level_q};
  assign half_ext = BW'(ww_q[WW_W-1:1]);

  // busy out of reset until the edges are loaded once, and after each write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= wr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q          <= lvl_ext - half_ext;
    high_q         <= lvl_ext + half_ext;
    cfg_q.thr_mode <= (ww_q == '0);
    cfg_q.out_max  <= omax_q;
    cfg_q.span     <= {ww_q[WW_W-1:1], 1'b0};
  end

  assign cfg_o  = cfg_q;
  assign low_o  = low_q;
  assign high_o = high_q;
  // hold off items while the edges settle after a write or after reset
  assign busy_o = busy_q;

endmodule

>>> design/wls_front.sv
// ----------------------------------------------------------------------------
// wls_front: classify and multiply stages
// Stage 1 compares against the band edges; stage 2 forms out_max * offset.
// ----------------------------------------------------------------------------
module wls_front import wls_pkg::*; #(
  parameter int IB = 17,
  parameter int BW = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic signed [BW-1:0] low_i,
  input  logic signed [BW-1:0] high_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IB-1:0]        voxel_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cls_e                 cls_o,
  output logic [PROD_W-1:0]    prod_o
);

  logic                 s1_valid_q, s2_valid_q;
  logic                 s1_en, s2_en;
  cls_e                 s1_cls_q, s2_cls_q;
  logic [QUO_W-1:0]     s1_ofs_q;
  logic [PROD_W-1:0]    s2_prod_q;
  logic signed [BW-1:0] v_ext;
  logic signed [BW-1:0] diff;
  logic                 ge_high, le_low;
  cls_e                 cls_d;

  assign s2_en      = !s2_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  // stage 1: band compare and offset from the low edge
  assign v_ext   = {{(BW-IB){voxel_i[IB-1]}}, voxel_i};
  assign ge_high = (v_ext >= high_i);
  assign le_low  = (v_ext <= low_i);
  assign diff    = v_ext - low_i;

  always_comb begin
    if (cfg_i.thr_mode) begin
      cls_d = ge_high ? CLS_FULL : CLS_ZERO;
    end else if (le_low) begin
      cls_d = CLS_ZERO;
    end else if (ge_high) begin
      cls_d = CLS_FULL;
    end else begin
      cls_d = CLS_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_cls_q <= cls_d;
      s1_ofs_q <= diff[QUO_W-1:0];  // inside the band the offset is below span
    end
    // stage 2: 16 x 16 product
    if (s2_en && s1_valid_q) begin
      s2_cls_q  <= s1_cls_q;
      s2_prod_q <= PROD_W'(cfg_i.out_max) * PROD_W'(s1_ofs_q);
    end
  end

  assign out_valid_o = s2_valid_q;
  assign cls_o       = s2_cls_q;
  assign prod_o      = s2_prod_q;

endmodule

>>> design/wls_div_pipe.sv
// ----------------------------------------------------------------------------
// wls_div_pipe: pipelined restoring divider
// One quotient bit per stage, most significant first; divisor is the span.
// ----------------------------------------------------------------------------
module wls_div_pipe import wls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WW_W-1:0]   span_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cls_e              cls_i,
  input  logic [PROD_W-1:0] num_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cls_e              cls_o,
  output logic [QUO_W-1:0]  quo_o
);

  localparam int NST = QUO_W;

  logic [NST-1:0]    val_q;
  logic [NST:0]      adv;
  logic [PROD_W-1:0] rem_q [NST];
  logic [QUO_W-1:0]  quo_q [NST];
  cls_e              cls_q [NST];

  // a stage moves when it is empty or the next one moves
  assign adv[NST] = out_ready_i;
  for (genvar s = 0; s < NST; s++) begin : g_adv
    assign adv[s] = !val_q[s] || adv[s+1];
  end
  assign in_ready_o = adv[0];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;

    logic              val_in;
    logic [PROD_W-1:0] rem_in, dsh, rem_d;
    logic [QUO_W-1:0]  quo_in, quo_d;
    cls_e              cls_in;

    if (s == 0) begin : g_first
      assign val_in = in_valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign cls_in = cls_i;
    end else begin : g_next
      assign val_in = val_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign cls_in = cls_q[s-1];
    end

    // trial subtract of the shifted divisor
    assign dsh = PROD_W'(span_i) << K;

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= dsh) begin
        rem_d    = rem_in - dsh;
        quo_d[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[s] <= 1'b0;
      end else if (adv[s]) begin
        val_q[s] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s] && val_in) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        cls_q[s] <= cls_in;
      end
    end
  end

  assign out_valid_o = val_q[NST-1];
  assign cls_o       = cls_q[NST-1];
  assign quo_o       = quo_q[NST-1];

endmodule

>>> design/window_level_stretch.sv
// ----------------------------------------------------------------------------
// window_level_stretch: window/level contrast stretch of a voxel stream
// Maps each voxel intensity to 0 .. out_max through the configured window.
// ----------------------------------------------------------------------------
// Usage:
//   voxel_i  : input items, one signed voxel_value each.
//   mapped_o : one mapped_value item per input item, in input order.
//   cfg_i    : register writes (0 window_width, 1 window_level, 2 out_max);
//              always ready, write only while no item is in flight.
// Throughput: one item per cycle unless mapped_o stalls or a write holds input.
//   Stages from the accepting edge to mapped_o.valid: classify, multiply, 16
//   divider stages, output register. One quotient bit per stage sets the depth.
// After a register write voxel_i.ready stays low for one cycle while the band
//   edges are recomputed.
// Reset clears all valid bits and loads width 256, level 128, out_max 255;
//   voxel_i.ready stays low for the first cycle after reset.
// When mapped_o stalls, stages with items hold them; empty stages keep
//   filling, so input is still taken until the pipeline is full.
// ----------------------------------------------------------------------------
module window_level_stretch import wls_pkg::*; #(
  parameter int INTENSITY_BITS = 17
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wls_voxel_if.sink  voxel_i,
  wls_map_if.source  mapped_o,
  wls_cfg_if.sink    cfg_i
);

  localparam int IB = INTENSITY_BITS;
  localparam int BW = ((IB > WW_W) ? IB : WW_W) + 2;
  localparam int DW = (IB > WW_W) ? IB : WW_W;

  cfg_t                 cfg;
  logic signed [BW-1:0] low, high;
  logic                 busy;
  logic                 fr_ready, fr_valid, dv_ready, dv_valid;
  cls_e                 fr_cls, dv_cls;
  logic [PROD_W-1:0]    fr_prod;
  logic [QUO_W-1:0]     dv_quo;
  logic                 out_en;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_data_q, out_data_d;

  wls_cfg_regs #(.IB(IB), .BW(BW), .DW(DW)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg),
    .low_o      (low),
    .high_o     (high),
    .busy_o     (busy)
  );

  assign voxel_i.ready = fr_ready && !busy;

  wls_front #(.IB(IB), .BW(BW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .low_i       (low),
    .high_i      (high),
    .in_valid_i  (voxel_i.valid && !busy),
    .in_ready_o  (fr_ready),
    .voxel_i     (voxel_i.voxel_value),
    .out_valid_o (fr_valid),
    .out_ready_i (dv_ready),
    .cls_o       (fr_cls),
    .prod_o      (fr_prod)
  );

  wls_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .span_i      (cfg.span),
    .in_valid_i  (fr_valid),
    .in_ready_o  (dv_ready),
    .cls_i       (fr_cls),
    .num_i       (fr_prod),
    .out_valid_o (dv_valid),
    .out_ready_i (out_en),
    .cls_o       (dv_cls),
    .quo_o       (dv_quo)
  );

  // output register: pick clamp value or quotient
  assign out_en = !out_valid_q || mapped_o.ready;

  always_comb begin
    case (dv_cls)
      CLS_ZERO: out_data_d = '0;
      CLS_FULL: out_data_d = cfg.out_max;
      CLS_DIV:  out_data_d = dv_quo;
      default:  out_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && dv_valid) begin
      out_data_q <= out_data_d;
    end
  end

  assign mapped_o.valid        = out_valid_q;
  assign mapped_o.mapped_value = out_data_q;

endmodule

>>> design/wls_checker.sv
// ----------------------------------------------------------------------------
// wls_checker: port-level checks of window_level_stretch
// Output handshake, result range and item accounting, bound to the top level.
// ----------------------------------------------------------------------------
module wls_checker import wls_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [OUT_W-1:0]     mapped_i,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_i,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [OUT_W-1:0]     cfg_data_i
);

  logic [OUT_W-1:0] omax_q;
  logic [7:0]       infl_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // shadow of out_max and count of items in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omax_q <= RST_OUT_MAX;
      infl_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i == REG_OUT_MAX) begin
        omax_q <= cfg_data_i;
      end
      infl_q <= infl_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("mapped item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(mapped_i))
    else $error("mapped value changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> mapped_i <= omax_q)
    else $error("mapped value above out_max");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> infl_q != '0)
    else $error("result item without an accepted input item");

endmodule

bind window_level_stretch wls_checker u_wls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (voxel_i.valid),
  .in_ready_i  (voxel_i.ready),
  .out_valid_i (mapped_o.valid),
  .out_ready_i (mapped_o.ready),
  .mapped_i    (mapped_o.mapped_value),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_index_i (cfg_i.index),
  .cfg_data_i  (cfg_i.wdata[15:0])
);
